// ----- sv/efr_pkg.sv -----
// Package: shared constants and types of the triangle rasterizer.
package efr_pkg;
  localparam int Lanes      = 32;
  localparam int CoordBits  = 10;
  localparam int SlopeBits  = CoordBits + 2;
  localparam int ValueBits  = 2 * CoordBits + 5;
  localparam int LaneBits   = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam int CovBits    = 32;
  localparam int QueueDepth = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [SlopeBits-1:0] a;
    logic [SlopeBits-1:0] b;
    logic [ValueBits-1:0] c0;
    logic                 tie;
  } edge_setup_t;

  // item handed from the front to the back
  typedef struct packed {
    logic                 is_load;
    edge_setup_t [2:0]    edges;
    logic [CoordBits-1:0] x_min;
    logic [CoordBits-1:0] x_max;
    logic [CoordBits-1:0] y_min;
    logic [CoordBits-1:0] y_max;
    logic [31:0]          color;
  } job_t;

  typedef struct packed {
    logic [9:0]  row_y;
    logic [9:0]  chunk_x;
    logic [31:0] coverage;
    logic [31:0] pixel_color;
    logic        last_chunk;
  } result_t;
endpackage

// ----- sv/efr_if.sv -----
// Interfaces: input and result channels of the rasterizer.
interface efr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [9:0]  vx0;
  logic [9:0]  vy0;
  logic [9:0]  vx1;
  logic [9:0]  vy1;
  logic [9:0]  vx2;
  logic [9:0]  vy2;
  logic [31:0] fill_color;
  modport source (output valid, command, vx0, vy0, vx1, vy1, vx2, vy2, fill_color,
                  input ready);
  modport sink (input valid, command, vx0, vy0, vx1, vy1, vx2, vy2, fill_color,
                output ready);
endinterface

interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  row_y;
  logic [9:0]  chunk_x;
  logic [31:0] coverage;
  logic [31:0] pixel_color;
  logic        last_chunk;
  modport source (output valid, row_y, chunk_x, coverage, pixel_color, last_chunk,
                  input ready);
  modport sink (input valid, row_y, chunk_x, coverage, pixel_color, last_chunk,
                output ready);
endinterface

// ----- sv/edge_function_triangle_rasterizer.sv -----
// Top level: half-space triangle rasterizer with top-left fill rule.
// Channels: in_ch carries items (command 0 loads three vertices and a colour,
// command 1 asks for the next chunk); out_ch returns one result per scan item
// while a scan is active: row, chunk x, 32-bit coverage mask, colour and a
// last-chunk flag. Load items and scans with nothing to scan give no result.
// Pipeline: an item is registered in the front (edge setup), passes a
// two-entry queue and is executed by the back, which registers the result.
// Throughput: one item per cycle while the receiver takes results; the back's
// chunk stepper handles one chunk per scan item, and the front and the queue
// keep accepting while it works.
// Reset (rst_n low, synchronous) empties the queue, drops any result and
// clears the scan state, so scan items give nothing until a load.
// When the receiver stalls the result holds in its register; the queue then
// fills and in_ready falls, no item is lost.
module edge_function_triangle_rasterizer (
  input  logic clk,
  input  logic rst_n,
  efr_in_if.sink    in_ch,
  efr_out_if.source out_ch
);
  logic          f_valid, f_ready, q_valid, q_ready;
  efr_pkg::job_t f_job, q_job;

  efr_front u_front (.clk, .rst_n, .in_ch, .job_valid(f_valid),
                     .job_ready(f_ready), .job(f_job));
  efr_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
                     .wr_data(f_job), .rd_valid(q_valid), .rd_ready(q_ready),
                     .rd_data(q_job));
  efr_back  u_back  (.clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready),
                     .job(q_job), .out_ch);
endmodule

// ----- sv/efr_front.sv -----
// Front: registers an item, forms box, edge functions and tie flags.
module efr_front (
  input  logic                clk,
  input  logic                rst_n,
  efr_in_if.sink              in_ch,
  output logic                job_valid,
  input  logic                job_ready,
  output efr_pkg::job_t       job
);
  localparam int CB = efr_pkg::CoordBits;
  localparam int SB = efr_pkg::SlopeBits;
  localparam int VB = efr_pkg::ValueBits;

  logic               stage_valid_r;
  logic               is_load_r;
  logic signed [SB-1:0] x_r [3];
  logic signed [SB-1:0] y_r [3];
  logic [31:0]        color_r;
  logic               take;

  assign in_ch.ready = !stage_valid_r || job_ready;
  assign take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid_r <= in_ch.valid;
    end
    if (take) begin
      is_load_r <= (in_ch.command == efr_pkg::CMD_LOAD);
      x_r[0] <= SB'({1'b0, in_ch.vx0[CB-1:0]});
      y_r[0] <= SB'({1'b0, in_ch.vy0[CB-1:0]});
      x_r[1] <= SB'({1'b0, in_ch.vx1[CB-1:0]});
      y_r[1] <= SB'({1'b0, in_ch.vy1[CB-1:0]});
      x_r[2] <= SB'({1'b0, in_ch.vx2[CB-1:0]});
      y_r[2] <= SB'({1'b0, in_ch.vy2[CB-1:0]});
      color_r <= in_ch.fill_color;
    end
  end

  // edge k uses vertices p,q with r off the edge
  function automatic efr_pkg::edge_setup_t make_edge(
    input logic signed [SB-1:0] px, py, qx, qy, rx, ry,
    input logic signed [SB-1:0] bx, by, input logic tie);
    logic signed [SB-1:0] a, b;
    logic signed [VB-1:0] c, f3, fb;
    efr_pkg::edge_setup_t e;
    a  = qy - py;
    b  = px - qx;
    c  = -(VB'(a) * VB'(px)) - (VB'(b) * VB'(py));
    f3 = VB'(a) * VB'(rx) + VB'(b) * VB'(ry) + c;
    fb = VB'(a) * VB'(bx) + VB'(b) * VB'(by) + c;
    // flip the edge so that the vertex off it lies on the covered side
    if (f3 < 0) begin
      a  = -a;
      b  = -b;
      fb = -fb;
    end
    e.a   = a;
    e.b   = b;
    e.c0  = fb;
    e.tie = tie;
    return e;
  endfunction

  function automatic logic tie_flag(input logic signed [SB-1:0] px, py, qx, qy);
    return (py < qy) || (py == qy && px >= qx);
  endfunction

  logic signed [SB-1:0] xmin, xmax, ymin, ymax;

  always_comb begin
    xmin = x_r[0]; xmax = x_r[0]; ymin = y_r[0]; ymax = y_r[0];
    for (int i = 1; i < 3; i++) begin
      if (x_r[i] < xmin) xmin = x_r[i];
      if (x_r[i] > xmax) xmax = x_r[i];
      if (y_r[i] < ymin) ymin = y_r[i];
      if (y_r[i] > ymax) ymax = y_r[i];
    end
    job.is_load  = is_load_r;
    job.edges[0] = make_edge(x_r[0], y_r[0], x_r[1], y_r[1], x_r[2], y_r[2],
                             xmin, ymin,
                             tie_flag(x_r[0], y_r[0], x_r[1], y_r[1]));
    job.edges[1] = make_edge(x_r[0], y_r[0], x_r[2], y_r[2], x_r[1], y_r[1],
                             xmin, ymin,
                             tie_flag(x_r[2], y_r[2], x_r[0], y_r[0]));
    job.edges[2] = make_edge(x_r[1], y_r[1], x_r[2], y_r[2], x_r[0], y_r[0],
                             xmin, ymin,
                             tie_flag(x_r[1], y_r[1], x_r[2], y_r[2]));
    job.x_min = xmin[CB-1:0];
    job.x_max = xmax[CB-1:0];
    job.y_min = ymin[CB-1:0];
    job.y_max = ymax[CB-1:0];
    job.color = color_r;
  end

  assign job_valid = stage_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !job_ready |=> stage_valid_r)
    else $error("front item dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !job_ready |=> $stable(is_load_r))
    else $error("front item changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!stage_valid_r || job_ready))
    else $error("front ready mismatch");
endmodule

// ----- sv/efr_queue.sv -----
// Queue: short FIFO of classified items between front and back.
module efr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  efr_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output efr_pkg::job_t rd_data
);
  localparam int D  = efr_pkg::QueueDepth;
  localparam int PB = (D > 1) ? $clog2(D) : 1;

  efr_pkg::job_t   mem_r [D];
  logic [PB-1:0]   wp_r, rp_r;
  logic [PB:0]     cnt_r;
  logic            wr, rd;

  assign wr_ready = cnt_r != (PB+1)'(D);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == PB'(D-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == PB'(D-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PB+1)'(wr) - (PB+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (PB+1)'(D))
    else $error("queue overfull");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count slip");
  assert property (@(posedge clk) disable iff (!rst_n)
    rd && !wr |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count slip on read");
endmodule

// ----- sv/efr_back.sv -----
// Back: steps through box chunks and produces coverage results.
module efr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  efr_pkg::job_t job,
  efr_out_if.source     out_ch
);
  localparam int CB = efr_pkg::CoordBits;
  localparam int SB = efr_pkg::SlopeBits;
  localparam int VB = efr_pkg::ValueBits;
  localparam int L  = efr_pkg::Lanes;
  localparam int NC = (L < 32) ? L : 32;
  localparam int XB = CB + 8;

  logic signed [SB-1:0] a_r [3];
  logic signed [SB-1:0] b_r [3];
  logic signed [VB-1:0] row_r [3];
  logic signed [VB-1:0] chk_r [3];
  logic [2:0]           tie_r;
  logic [CB-1:0]        xmin_r, xmax_r, ymax_r, sx_r, sy_r;
  logic                 active_r;
  logic [31:0]          color_r;

  logic                 ovalid_r;
  efr_pkg::result_t     res_r;
  logic                 take, out_free;
  logic [31:0]          cov;
  logic [XB-1:0]        nx;
  logic                 row_end, last;

  assign out_free  = !ovalid_r || out_ch.ready;
  assign job_ready = out_free;
  assign take      = job_valid && job_ready;

  always_comb begin
    logic signed [VB-1:0] f;
    logic in;
    cov = '0;
    for (int i = 0; i < NC; i++) begin
      in = (XB'(sx_r) + XB'(i)) <= XB'(xmax_r);
      for (int k = 0; k < 3; k++) begin
        f = chk_r[k] + VB'(a_r[k]) * VB'(i);
        if (f < 0 || (f == 0 && !tie_r[k])) in = 1'b0;
      end
      cov[i] = in;
    end
    nx      = XB'(sx_r) + XB'(L);
    row_end = nx > XB'(xmax_r);
    last    = row_end && (sy_r >= ymax_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
      a_r <= '{default: '0}; b_r <= '{default: '0};
      row_r <= '{default: '0}; chk_r <= '{default: '0};
      tie_r <= '0; xmin_r <= '0; xmax_r <= '0; ymax_r <= '0;
      sx_r <= '0; sy_r <= '0; color_r <= '0;
    end else begin
      if (out_ch.ready && !(take && !job.is_load && active_r)) ovalid_r <= 1'b0;
      if (take) begin
        if (job.is_load) begin
          for (int k = 0; k < 3; k++) begin
            a_r[k]   <= job.edges[k].a;
            b_r[k]   <= job.edges[k].b;
            row_r[k] <= job.edges[k].c0;
            chk_r[k] <= job.edges[k].c0;
            tie_r[k] <= job.edges[k].tie;
          end
          xmin_r <= job.x_min; xmax_r <= job.x_max; ymax_r <= job.y_max;
          sx_r <= job.x_min; sy_r <= job.y_min;
          color_r <= job.color;
          active_r <= 1'b1;
        end else if (active_r) begin
          ovalid_r <= 1'b1;
          res_r.row_y       <= 10'(sy_r);
          res_r.chunk_x     <= 10'(sx_r);
          res_r.coverage    <= cov;
          res_r.pixel_color <= color_r;
          res_r.last_chunk  <= last;
          if (row_end) begin
            if (last) begin
              active_r <= 1'b0;
            end else begin
              for (int k = 0; k < 3; k++) begin
                row_r[k] <= row_r[k] + VB'(b_r[k]);
                chk_r[k] <= row_r[k] + VB'(b_r[k]);
              end
              sy_r <= sy_r + 1'b1;
              sx_r <= xmin_r;
            end
          end else begin
            for (int k = 0; k < 3; k++)
              chk_r[k] <= chk_r[k] + VB'(a_r[k]) * VB'(L);
            sx_r <= nx[CB-1:0];
          end
        end
      end
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.row_y       = res_r.row_y;
  assign out_ch.chunk_x     = res_r.chunk_x;
  assign out_ch.coverage    = res_r.coverage;
  assign out_ch.pixel_color = res_r.pixel_color;
  assign out_ch.last_chunk  = res_r.last_chunk;

  assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(res_r))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    take && !job.is_load && active_r && last |=> !active_r)
    else $error("scan not closed on last chunk");
  assert property (@(posedge clk) disable iff (!rst_n)
    take && job.is_load |=> active_r)
    else $error("load did not start scan");
endmodule
